>>> rtl/core/mfu_pkg.sv
package mfu_pkg;

    localparam int NUM_SLOTS_DEF   = 7;
    localparam int QUEUE_DEPTH_DEF = 2;

    // slot identifier registers sit at indices 0..ID_REGS-1, the mask after them
    localparam int ID_REGS   = 7;
    localparam int ID_W      = 11;
    localparam int ID_BASE   = 513;
    localparam int MASK_W    = 7;
    localparam int MASK_RST  = 115;
    localparam int SLOT_W    = 3;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MASK = CFG_IDX_W'(ID_REGS);

    localparam int STEP_LIMIT = 4095;
    localparam int TURN_CORR  = 8191;

    localparam int ANGLE_W = 16;
    localparam int SUM_W   = 32;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 4;

    // classified frame handed from front to back
    typedef struct packed {
        logic                      matched;
        logic [SLOT_W-1:0]         slot;
        logic                      unwrap;
        logic [ANGLE_W-1:0]        angle;
        logic signed [ANGLE_W-1:0] speed;
        logic signed [ANGLE_W-1:0] current;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> rtl/core/mfu_front.sv
module mfu_front #(
    parameter int NUM_SLOTS = mfu_pkg::NUM_SLOTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mfu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mfu_pkg::CFG_DAT_W-1:0]    cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mfu_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [mfu_pkg::ID_W-1:0]         s_tuser,
    input  mfu_pkg::q_status_t               q_status,
    output logic                             q_push,
    output mfu_pkg::entry_t                  q_entry
);

    localparam int NUM_ID = (NUM_SLOTS < mfu_pkg::ID_REGS) ? NUM_SLOTS : mfu_pkg::ID_REGS;

    logic [mfu_pkg::ID_W-1:0]   slot_id_reg [NUM_ID];
    logic [mfu_pkg::MASK_W-1:0] mask_reg;
    logic                       hit;
    logic [mfu_pkg::SLOT_W-1:0] hit_slot;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_ID; i++) begin
                slot_id_reg[i] <= mfu_pkg::ID_W'(mfu_pkg::ID_BASE + i);
            end
            mask_reg <= mfu_pkg::MASK_W'(mfu_pkg::MASK_RST);
        end else if (cfg_valid) begin
            for (int i = 0; i < NUM_ID; i++) begin
                if (cfg_index == mfu_pkg::CFG_IDX_W'(i)) begin
                    slot_id_reg[i] <= cfg_data[mfu_pkg::ID_W-1:0];
                end
            end
            if (cfg_index == mfu_pkg::CFG_IDX_MASK) begin
                mask_reg <= cfg_data[mfu_pkg::MASK_W-1:0];
            end
        end
    end

    // lowest matching slot wins: scan from the top down
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = NUM_ID - 1; i >= 0; i--) begin
            if (slot_id_reg[i] == s_tuser) begin
                hit      = 1'b1;
                hit_slot = mfu_pkg::SLOT_W'(i);
            end
        end
    end

    assign s_tready = !q_status.full;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        q_entry = '0;
        if (hit) begin
            q_entry.matched = 1'b1;
            q_entry.slot    = hit_slot;
            q_entry.unwrap  = mask_reg[hit_slot];
            q_entry.angle   = {s_tdata[7:0], s_tdata[15:8]};
            q_entry.speed   = {s_tdata[23:16], s_tdata[31:24]};
            q_entry.current = {s_tdata[39:32], s_tdata[47:40]};
        end
    end

endmodule

>>> rtl/core/mfu_queue.sv
module mfu_queue #(
    parameter int DEPTH = mfu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  mfu_pkg::entry_t     push_entry,
    input  logic                pop,
    output mfu_pkg::entry_t     pop_entry,
    output mfu_pkg::q_status_t  status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mfu_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_entry    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !status.full)
        else $error("queue pushed while full");

endmodule

>>> rtl/core/mfu_back.sv
module mfu_back #(
    parameter int NUM_SLOTS = mfu_pkg::NUM_SLOTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mfu_pkg::q_status_t               q_status,
    input  mfu_pkg::entry_t                  q_entry,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mfu_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [mfu_pkg::M_TUSER_W-1:0]    m_tuser
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [mfu_pkg::ANGLE_W-1:0] NEG_LIMIT =
        mfu_pkg::ANGLE_W'(65536 - mfu_pkg::STEP_LIMIT);
    localparam logic [mfu_pkg::ANGLE_W-1:0] POS_LIMIT =
        mfu_pkg::ANGLE_W'(mfu_pkg::STEP_LIMIT);

    logic [mfu_pkg::ANGLE_W-1:0] prev_angle_reg [NUM_SLOTS];
    logic [mfu_pkg::SUM_W-1:0]   turn_sum_reg   [NUM_SLOTS];

    logic                               out_valid_reg;
    logic                               out_matched_reg;
    logic [mfu_pkg::SLOT_W-1:0]         out_slot_reg;
    logic [mfu_pkg::ANGLE_W-1:0]        out_angle_reg;
    logic signed [mfu_pkg::ANGLE_W-1:0] out_speed_reg;
    logic signed [mfu_pkg::ANGLE_W-1:0] out_current_reg;
    logic [mfu_pkg::SUM_W-1:0]          out_total_reg;

    logic [IDX_W-1:0]            idx;
    logic [mfu_pkg::ANGLE_W-1:0] diff;
    logic [mfu_pkg::SUM_W-1:0]   step;
    logic [mfu_pkg::SUM_W-1:0]   sum_next;
    logic                        upd;

    // advance when the output register is free or being drained
    assign q_pop = !q_status.empty && (!out_valid_reg || m_tready);
    assign idx   = q_entry.slot[IDX_W-1:0];
    assign upd   = q_entry.matched && q_entry.unwrap;

    always_comb begin
        diff = q_entry.angle - prev_angle_reg[idx];
        step = {{(mfu_pkg::SUM_W - mfu_pkg::ANGLE_W){diff[mfu_pkg::ANGLE_W-1]}}, diff};
        // fold a large step back by TURN_CORR towards zero
        if (diff[mfu_pkg::ANGLE_W-1] && (diff < NEG_LIMIT)) begin
            step = step + mfu_pkg::SUM_W'(mfu_pkg::TURN_CORR);
        end else if (!diff[mfu_pkg::ANGLE_W-1] && (diff > POS_LIMIT)) begin
            step = step - mfu_pkg::SUM_W'(mfu_pkg::TURN_CORR);
        end
        sum_next = turn_sum_reg[idx] + step;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                prev_angle_reg[i] <= '0;
                turn_sum_reg[i]   <= '0;
            end
        end else if (q_pop && upd) begin
            prev_angle_reg[idx] <= q_entry.angle;
            turn_sum_reg[idx]   <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (q_pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_matched_reg <= q_entry.matched;
            out_slot_reg    <= q_entry.slot;
            out_angle_reg   <= q_entry.angle;
            out_speed_reg   <= q_entry.speed;
            out_current_reg <= q_entry.current;
            if (!q_entry.matched) begin
                out_total_reg <= '0;
            end else if (q_entry.unwrap) begin
                out_total_reg <= sum_next;
            end else begin
                out_total_reg <= turn_sum_reg[idx];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_total_reg, out_current_reg, out_speed_reg, out_angle_reg};
    assign m_tuser  = {out_slot_reg, out_matched_reg};

    a_unmatched_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_matched_reg) |-> (out_slot_reg == '0 && out_total_reg == '0))
        else $error("unmatched beat carries a slot or sum");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_matched_reg) |-> (out_slot_reg < mfu_pkg::SLOT_W'(NUM_SLOTS)))
        else $error("matched beat names a slot out of range");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && upd) |=> out_total_reg == turn_sum_reg[$past(idx)])
        else $error("reported sum differs from stored sum");

endmodule

>>> rtl/core/motor_feedback_unwrap_unit.sv
// Channel   Dir  Handshake              Payload
// s_        in   s_tvalid / s_tready    tuser: frame_id; tdata: byte0..byte5
// m_        out  m_tvalid / m_tready    tuser: matched, slot; tdata: angle .. angle_total
// cfg_      in   cfg_valid / cfg_ready  cfg_index, cfg_data (ready always high)
//
// One beat per cycle in both directions while s_tready and m_tready stay high. A frame taken
// on s_ passes through the queue entry and then the output register before it shows on m_;
// the per-slot read-modify-write of angle and turn sum happens in the pop cycle and adds no
// register of its own.
// Reset (aresetn low at a clock edge) restores slot identifiers and mask and clears
// all slot state and the queue at once; the block takes frames on the next cycle.
// s_tready drops only when the queue is full, which needs m_tready held low.
module motor_feedback_unwrap_unit #(
    parameter int NUM_SLOTS   = mfu_pkg::NUM_SLOTS_DEF,
    parameter int QUEUE_DEPTH = mfu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mfu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mfu_pkg::CFG_DAT_W-1:0]    cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // byte0 [7:0], byte1, byte2, byte3, byte4, byte5 [47:40]
    input  logic [mfu_pkg::S_TDATA_W-1:0]    s_tdata,
    // frame_id [10:0]
    input  logic [mfu_pkg::ID_W-1:0]         s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // angle [15:0], speed [31:16], current [47:32], angle_total [79:48]
    output logic [mfu_pkg::M_TDATA_W-1:0]    m_tdata,
    // matched [0], slot [3:1]
    output logic [mfu_pkg::M_TUSER_W-1:0]    m_tuser
);

    mfu_pkg::q_status_t q_status;
    mfu_pkg::entry_t    push_entry;
    mfu_pkg::entry_t    pop_entry;
    logic               q_push;
    logic               q_pop;

    mfu_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    mfu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .status     (q_status)
    );

    mfu_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_entry  (pop_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
